// File: src/mmrp_pkg.sv
// Package for the meter response parser: frame layout constants, status codes,
// result struct and the byte-wide CRC-16 update.
// No dependencies.
package mmrp_pkg;

    localparam int FRAME_LEN  = 25;   // bytes in a full read-input response
    localparam int CRC_LEN    = 23;   // bytes covered by the CRC
    localparam int CELLS      = FRAME_LEN - 1;
    localparam int CNT_W      = $clog2(FRAME_LEN + 1);

    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  DATA_BYTES      = 8'd20;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [31:0] THRESH_RESET    = 32'd10;

    typedef enum logic [1:0] {
        KIND_FLUSH = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_SHORT   = 3'd2,
        ST_FRAMING = 3'd3,
        ST_CRC     = 3'd4
    } status_t;

    // byte j of the frame sits at index j
    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] voltage_raw;
        logic [31:0] current_raw;
        logic [31:0] power_raw;
        logic [31:0] energy_raw;
        logic        load_in_use;
        logic        in_use_changed;
    } result_t;

    // reflected CRC-16, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: src/mmrp_req_if.sv
// Request channel of the meter response parser: valid/ready plus kind and byte.
// Depends on nothing.
interface mmrp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// File: src/mmrp_res_if.sv
// Result channel of the meter response parser: valid/ready plus status and values.
// Depends on nothing.
interface mmrp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] voltage_raw;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic        load_in_use;
    logic        in_use_changed;

    modport source (output valid, output status, output voltage_raw, output current_raw,
                    output power_raw, output energy_raw, output load_in_use,
                    output in_use_changed, input ready);
    modport sink   (input valid, input status, input voltage_raw, input current_raw,
                    input power_raw, input energy_raw, input load_in_use,
                    input in_use_changed, output ready);
endinterface

// File: src/mmrp_byte_cell.sv
// One byte cell of the frame capture chain: loads its neighbor's byte on shift.
// Depends on nothing.
module mmrp_byte_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
            byte_reg <= d;
    end

    assign q = byte_reg;

endmodule

// File: src/mmrp_frame_check.sv
// Checks a complete frame (framing, CRC) and unpacks the meter values.
// Depends on mmrp_pkg.
module mmrp_frame_check (
    input  mmrp_pkg::frame_t  frame,
    input  logic [15:0]       crc,
    input  logic [31:0]       threshold,
    input  logic              ever_published,
    input  logic              last_in_use,
    output mmrp_pkg::result_t result
);

    logic [31:0] power;
    logic        in_use;
    logic [15:0] crc_got;

    assign power   = {frame[11], frame[12], frame[9], frame[10]};
    assign in_use  = power > threshold;
    assign crc_got = {frame[24], frame[23]};   // sent low byte first

    always_comb
    begin
        result = '0;
        if (frame[1] != mmrp_pkg::FUNC_READ_INPUT || frame[2] != mmrp_pkg::DATA_BYTES)
        begin
            result.status = mmrp_pkg::ST_FRAMING;
        end
        else if (crc_got != crc)
        begin
            result.status = mmrp_pkg::ST_CRC;
        end
        else
        begin
            result.status         = mmrp_pkg::ST_OK;
            result.voltage_raw    = {frame[3], frame[4]};
            result.current_raw    = {frame[7], frame[8], frame[5], frame[6]};
            result.power_raw      = power;
            result.energy_raw     = {frame[15], frame[16], frame[13], frame[14]};
            result.load_in_use    = in_use;
            result.in_use_changed = !ever_published || (in_use != last_in_use);
        end
    end

endmodule

// File: src/modbus_meter_response_parser.sv
// Top level of the meter response parser: byte cell chain, CRC, control, result register.
// Depends on mmrp_pkg, mmrp_req_if, mmrp_res_if, mmrp_byte_cell, mmrp_frame_check.
//
// Takes one request per clock: flush, received byte or window close. Bytes shift
// through a chain of 24 byte cells while a byte-wide CRC-16 runs over bytes 0..22;
// the 25th byte is checked together with the chain contents in the same cycle.
// A result (status plus meter values) is loaded into the output register by the
// request that ends the frame, and a new request is taken every cycle
// as long as that register is empty or being read. Only a held, unread result
// stops request intake. The in-use threshold resets to 10 and is written through
// cfg_we / cfg_wdata; the user must write it only while the block is idle, the block does not enforce it.
module modbus_meter_response_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    mmrp_req_if.sink    req,
    mmrp_res_if.source  res
);

    localparam int CELLS = mmrp_pkg::CELLS;

    logic [31:0]                  thresh_reg;
    logic [mmrp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [15:0]                  crc_reg, crc_next;
    logic                         reported_reg, reported_next;
    logic                         last_in_use_reg, last_in_use_next;
    logic                         ever_pub_reg, ever_pub_next;
    logic                         res_valid_reg, res_valid_next;
    mmrp_pkg::result_t            res_reg, res_next;

    logic               accept;
    logic               store;
    logic               emit;
    logic [7:0]         cell_q [CELLS];
    mmrp_pkg::frame_t   frame;
    mmrp_pkg::result_t  check;
    mmrp_pkg::kind_t    kind;

    assign kind   = mmrp_pkg::kind_t'(req.kind);
    assign req.ready = !res_valid_reg || res.ready;
    assign accept = req.valid && req.ready;
    assign store  = accept && kind == mmrp_pkg::KIND_BYTE && !reported_reg
                    && count_reg < mmrp_pkg::CNT_W'(mmrp_pkg::FRAME_LEN);

    // cell 0 takes the newest byte; cell k holds frame byte (count - 1 - k)
    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                mmrp_byte_cell u_cell (.clk(clk), .shift(store), .d(req.rx_byte), .q(cell_q[g]));
            end
            else
            begin : g_body
                mmrp_byte_cell u_cell (.clk(clk), .shift(store), .d(cell_q[g-1]), .q(cell_q[g]));
            end
        end
    endgenerate

    always_comb
    begin
        for (int j = 0; j < CELLS; j++)
            frame[j] = cell_q[CELLS-1-j];
        frame[mmrp_pkg::FRAME_LEN-1] = req.rx_byte;
    end

    mmrp_frame_check u_check (
        .frame          (frame),
        .crc            (crc_reg),
        .threshold      (thresh_reg),
        .ever_published (ever_pub_reg),
        .last_in_use    (last_in_use_reg),
        .result         (check)
    );

    always_comb
    begin
        count_next       = count_reg;
        crc_next         = crc_reg;
        reported_next    = reported_reg;
        last_in_use_next = last_in_use_reg;
        ever_pub_next    = ever_pub_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && !res.ready;
        emit             = 1'b0;
        if (accept)
        begin
            case (kind)
                mmrp_pkg::KIND_FLUSH:
                begin
                    count_next    = '0;
                    crc_next      = mmrp_pkg::CRC_SEED;
                    reported_next = 1'b0;
                end
                mmrp_pkg::KIND_BYTE:
                begin
                    if (store)
                    begin
                        count_next = count_reg + 1'b1;
                        if (count_reg < mmrp_pkg::CNT_W'(mmrp_pkg::CRC_LEN))
                            crc_next = mmrp_pkg::crc_byte(crc_reg, req.rx_byte);
                        if (count_reg == mmrp_pkg::CNT_W'(mmrp_pkg::FRAME_LEN - 1))
                        begin
                            emit = 1'b1;
                            res_next = check;
                            if (check.status == mmrp_pkg::ST_OK)
                            begin
                                last_in_use_next = check.load_in_use;
                                ever_pub_next    = 1'b1;
                            end
                        end
                    end
                end
                mmrp_pkg::KIND_CLOSE:
                begin
                    if (!reported_reg)
                    begin
                        emit = 1'b1;
                        res_next = '0;
                        res_next.status = (count_reg == '0) ? mmrp_pkg::ST_TIMEOUT
                                                            : mmrp_pkg::ST_SHORT;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            reported_next  = 1'b1;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg      <= mmrp_pkg::THRESH_RESET;
            count_reg       <= '0;
            crc_reg         <= mmrp_pkg::CRC_SEED;
            reported_reg    <= 1'b0;
            last_in_use_reg <= 1'b0;
            ever_pub_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thresh_reg <= cfg_wdata;
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            reported_reg    <= reported_next;
            last_in_use_reg <= last_in_use_next;
            ever_pub_reg    <= ever_pub_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.status         = res_reg.status;
    assign res.voltage_raw    = res_reg.voltage_raw;
    assign res.current_raw    = res_reg.current_raw;
    assign res.power_raw      = res_reg.power_raw;
    assign res.energy_raw     = res_reg.energy_raw;
    assign res.load_in_use    = res_reg.load_in_use;
    assign res.in_use_changed = res_reg.in_use_changed;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mmrp_pkg::CNT_W'(mmrp_pkg::FRAME_LEN))
        else $error("byte count past frame length");

    a_full_reported: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == mmrp_pkg::CNT_W'(mmrp_pkg::FRAME_LEN) |-> reported_reg)
        else $error("full frame without a report");

    a_emit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> reported_reg && res_valid_reg)
        else $error("result emitted without marking the response");

    a_ok_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_next.status == mmrp_pkg::ST_OK) |=>
            ever_pub_reg && last_in_use_reg == res_reg.load_in_use)
        else $error("valid frame not published");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |-> !req.ready)
        else $error("request taken while result register held");

endmodule

// File: dv/mmrp_response_checker.sv
`timescale 1ns / 100ps
// Response checker for the meter response parser: follows every accepted request,
// predicts the result it causes and compares it with the result channel.
// Depends on mmrp_pkg, mmrp_req_if and mmrp_res_if.
module mmrp_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    mmrp_req_if         req,
    mmrp_res_if         res,
    output int          mismatches,
    output int          outstanding
);

    logic [31:0]         threshold;
    int                  rx_count;
    logic [15:0]         rx_crc;
    logic [7:0]          rx_frame [mmrp_pkg::FRAME_LEN];
    logic                frame_done;
    logic                prev_in_use;
    logic                published;
    mmrp_pkg::result_t   expected_readings [$];

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    // advance the frame state by one request; queue the reading it produces
    task automatic parse_request(mmrp_pkg::kind_t k, logic [7:0] b);
        mmrp_pkg::result_t r;
        r = '0;
        case (k)
            mmrp_pkg::KIND_FLUSH:
            begin
                rx_count   = 0;
                rx_crc     = mmrp_pkg::CRC_SEED;
                frame_done = 1'b0;
            end
            mmrp_pkg::KIND_BYTE:
            begin
                if (!frame_done && rx_count < mmrp_pkg::FRAME_LEN)
                begin
                    rx_frame[rx_count] = b;
                    if (rx_count < mmrp_pkg::CRC_LEN)
                        rx_crc = crc16_update(rx_crc, b);
                    rx_count++;
                    if (rx_count == mmrp_pkg::FRAME_LEN)
                    begin
                        if (rx_frame[1] != mmrp_pkg::FUNC_READ_INPUT
                            || rx_frame[2] != mmrp_pkg::DATA_BYTES)
                            r.status = mmrp_pkg::ST_FRAMING;
                        else if ({rx_frame[24], rx_frame[23]} != rx_crc)
                            r.status = mmrp_pkg::ST_CRC;
                        else
                        begin
                            r.status      = mmrp_pkg::ST_OK;
                            r.voltage_raw = {rx_frame[3], rx_frame[4]};
                            // 32-bit values arrive low word first, each word high byte first
                            r.current_raw = {rx_frame[7], rx_frame[8], rx_frame[5], rx_frame[6]};
                            r.power_raw   = {rx_frame[11], rx_frame[12], rx_frame[9], rx_frame[10]};
                            r.energy_raw  = {rx_frame[15], rx_frame[16], rx_frame[13], rx_frame[14]};
                            r.load_in_use = r.power_raw > threshold;
                            r.in_use_changed = !published || (r.load_in_use != prev_in_use);
                            prev_in_use   = r.load_in_use;
                            published     = 1'b1;
                        end
                        frame_done = 1'b1;
                        expected_readings.push_back(r);
                    end
                end
            end
            mmrp_pkg::KIND_CLOSE:
            begin
                if (!frame_done)
                begin
                    r.status   = (rx_count == 0) ? mmrp_pkg::ST_TIMEOUT : mmrp_pkg::ST_SHORT;
                    frame_done = 1'b1;
                    expected_readings.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mmrp_pkg::result_t want;
        if (!rst_n)
        begin
            threshold   = mmrp_pkg::THRESH_RESET;
            rx_count    = 0;
            rx_crc      = mmrp_pkg::CRC_SEED;
            frame_done  = 1'b0;
            prev_in_use = 1'b0;
            published   = 1'b0;
            mismatches  = 0;
            expected_readings.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                threshold = cfg_wdata;
            if (req.valid && req.ready)
                parse_request(mmrp_pkg::kind_t'(req.kind), req.rx_byte);
            if (res.valid && res.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result with no request behind it: status %0d", res.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("status", 32'(want.status), 32'(res.status));
                    check_field("voltage_raw", 32'(want.voltage_raw), 32'(res.voltage_raw));
                    check_field("current_raw", want.current_raw, res.current_raw);
                    check_field("power_raw", want.power_raw, res.power_raw);
                    check_field("energy_raw", want.energy_raw, res.energy_raw);
                    check_field("load_in_use", 32'(want.load_in_use), 32'(res.load_in_use));
                    check_field("in_use_changed", 32'(want.in_use_changed),
                                32'(res.in_use_changed));
                end
            end
            outstanding <= expected_readings.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the meter response parser bench: clock, reset, request and result traffic,
// threshold writes and the verdict. Depends on mmrp_pkg, both channel interfaces,
// modbus_meter_response_parser and mmrp_response_checker.
module testbench;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          mismatches;
    int          outstanding;
    int          quiet = 0;
    bit          src_gaps;
    bit          sink_gaps;
    bit          hold_ask;
    bit          hold_done;
    logic [31:0] thr_now;
    logic [7:0]  frame_buf [mmrp_pkg::FRAME_LEN];

    mmrp_req_if req_ch ();
    mmrp_res_if res_ch ();

    modbus_meter_response_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    mmrp_response_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // nothing accepted on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet <= 0;
        else if (quiet == STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_ask && !hold_done)
            begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (sink_gaps && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    task automatic send_request(mmrp_pkg::kind_t k, logic [7:0] b);
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= k;
        req_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_request(mmrp_pkg::KIND_NONE, 8'($urandom_range(0, 255)));
            send_request(mmrp_pkg::KIND_BYTE, frame_buf[i]);
        end
    endtask

    task automatic seal_frame();
        logic [15:0] c;
        c = mmrp_pkg::CRC_SEED;
        for (int i = 0; i < mmrp_pkg::CRC_LEN; i++)
            c = crc16_next(c, frame_buf[i]);
        frame_buf[23] = c[7:0];
        frame_buf[24] = c[15:8];
    endtask

    // well-formed response; power often lands right at the threshold
    task automatic build_frame();
        logic [31:0] pw;
        frame_buf[0] = 8'($urandom_range(0, 255));
        frame_buf[1] = mmrp_pkg::FUNC_READ_INPUT;
        frame_buf[2] = mmrp_pkg::DATA_BYTES;
        for (int i = 3; i < mmrp_pkg::CRC_LEN; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
            0:       pw = 32'd0;
            1:       pw = thr_now;
            2:       pw = thr_now + 32'd1;
            3:       pw = thr_now - 32'd1;
            4:       pw = 32'hFFFF_FFFF;
            5:       pw = $urandom;
            default: pw = $urandom_range(0, 40);
        endcase
        {frame_buf[11], frame_buf[12], frame_buf[9], frame_buf[10]} = pw;
        seal_frame();
    endtask

    task automatic run_response();
        int pick;
        int n;
        logic [7:0] v;
        logic [7:0] good;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0)
            send_request(mmrp_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)));
        if (pick < 60)
        begin
            build_frame();
            send_bytes(mmrp_pkg::FRAME_LEN);
        end
        else if (pick < 68)
        begin
            // one flipped bit anywhere but the framing bytes
            build_frame();
            n = $urandom_range(2, mmrp_pkg::FRAME_LEN - 1);
            if (n == 2)
                n = 0;
            frame_buf[n] = frame_buf[n] ^ (8'h01 << $urandom_range(0, 7));
            send_bytes(mmrp_pkg::FRAME_LEN);
        end
        else if (pick < 80)
        begin
            build_frame();
            n    = (pick < 74) ? 1 : 2;
            good = (n == 1) ? mmrp_pkg::FUNC_READ_INPUT : mmrp_pkg::DATA_BYTES;
            do
                v = 8'($urandom_range(0, 255));
            while (v == good);
            frame_buf[n] = v;
            if ($urandom_range(0, 3) != 0)
                seal_frame();
            send_bytes(mmrp_pkg::FRAME_LEN);
        end
        else if (pick < 90)
        begin
            build_frame();
            send_bytes($urandom_range(1, mmrp_pkg::FRAME_LEN - 1));
            send_request(mmrp_pkg::KIND_CLOSE, 8'($urandom_range(0, 255)));
        end
        else if (pick < 95)
            send_request(mmrp_pkg::KIND_CLOSE, 8'($urandom_range(0, 255)));
        else
        begin
            // aborted response, then a clean one
            build_frame();
            send_bytes($urandom_range(1, mmrp_pkg::FRAME_LEN - 1));
            send_request(mmrp_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)));
            build_frame();
            send_bytes(mmrp_pkg::FRAME_LEN);
        end
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                repeat ($urandom_range(1, 3))
                    send_request(mmrp_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
            end
            3, 4:    send_request(mmrp_pkg::KIND_CLOSE, 8'($urandom_range(0, 255)));
            5:       send_request(mmrp_pkg::KIND_NONE, 8'($urandom_range(0, 255)));
            default:
            begin
            end
        endcase
    endtask

    // stop offering and let every pending result drain out
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_now   = value;
    endtask

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.kind    = mmrp_pkg::KIND_FLUSH;
        req_ch.rx_byte = 8'h00;
        cfg_we         = 1'b0;
        cfg_wdata      = 32'd0;
        src_gaps       = 1'b0;
        sink_gaps      = 1'b0;
        hold_ask       = 1'b0;
        thr_now        = mmrp_pkg::THRESH_RESET;
        rst_n          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // close right after reset times out; a second close and stray bytes do nothing
        send_request(mmrp_pkg::KIND_CLOSE, 8'h00);
        send_request(mmrp_pkg::KIND_CLOSE, 8'hFF);
        send_request(mmrp_pkg::KIND_NONE, 8'hA5);
        send_request(mmrp_pkg::KIND_BYTE, 8'h5A);
        send_request(mmrp_pkg::KIND_FLUSH, 8'hFF);
        send_request(mmrp_pkg::KIND_BYTE, 8'h00);
        send_request(mmrp_pkg::KIND_CLOSE, 8'h00);
        // all-ones payload: largest values, first published reading
        send_request(mmrp_pkg::KIND_FLUSH, 8'h00);
        build_frame();
        frame_buf[0] = 8'h00;
        for (int i = 3; i < mmrp_pkg::CRC_LEN; i++)
            frame_buf[i] = 8'hFF;
        seal_frame();
        send_bytes(mmrp_pkg::FRAME_LEN);
        send_request(mmrp_pkg::KIND_BYTE, 8'hFF);
        send_request(mmrp_pkg::KIND_CLOSE, 8'h00);

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1:       write_threshold(32'd0);
                    2:       write_threshold(32'hFFFF_FFFF);
                    3:       write_threshold($urandom);
                    4:       write_threshold($urandom_range(1, 1000));
                    default: write_threshold(mmrp_pkg::THRESH_RESET);
                endcase
            end
            for (int n = 0; n < 12; n++)
            begin
                src_gaps  = (p < 5) && ($urandom_range(0, 3) != 0);
                sink_gaps = (p < 5) && ($urandom_range(0, 3) != 0);
                if (p == 1 && n == 3)
                    hold_ask = 1'b1;
                run_response();
            end
        end

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: modbus_meter_response_parser.f
src/mmrp_pkg.sv
src/mmrp_req_if.sv
src/mmrp_res_if.sv
src/mmrp_byte_cell.sv
src/mmrp_frame_check.sv
src/modbus_meter_response_parser.sv
dv/mmrp_response_checker.sv
dv/testbench.sv
